// File: rtl/core/kthc_pkg.sv
// Shared types and codes for the keyed table with hit counters.
`timescale 1ns / 1ps

package kthc_pkg;

	localparam int OP_W     = 3;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int HITS_W   = 16;
	localparam int OCC_W    = 5;
	localparam int TOTAL_W  = 32;
	localparam int M_DATA_W = 64;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_LOOKUP = 3'd2,
		OP_HIT    = 3'd3,
		OP_COUNT  = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_t;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic             fire;
		logic [OP_W-1:0]  op;
		logic [KEY_W-1:0] key;
	} cell_cmd_t;

endpackage

// File: rtl/core/keyed_table_with_hit_counters_core.sv
// Top level of the keyed table with hit counters: command register, cell row, result register.
`timescale 1ns / 1ps

// Keyed table of ENTRIES slots, each with a valid flag, a 32-bit key and a
// saturating 16-bit hit counter.
// Command channel (s_axis_*): one beat per operation; tuser carries the
// operation code (insert, delete, lookup, hit, count), tdata the key.
// Result channel (m_axis_*): exactly one beat per command, in order; tuser
// carries the status, tdata the slot, entry hits, occupancy and total hits.
// A command accepted into the command register executes from there and its
// result is written into the result register. Throughput: one command per
// cycle while results are taken, as every cell compares its key in parallel
// and the lowest claiming slot is found along the cell row's priority link.
// The state updated by a command is seen by the command behind it.
// When the receiver stalls, the result stays in the output register, one more
// command may be taken into the command register, and then s_axis_tready
// drops until the result beat leaves.
// Reset clears every valid flag, the occupancy and the total; keys and
// counters are rewritten on insert, so no clearing pass is needed.
module keyed_table_with_hit_counters_core #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] key
	input  logic [2:0]  s_axis_tuser,  // [2:0] operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // [3:0] slot, [19:4] entry_hits,
	                                   // [24:20] occupied, [56:25] total_hits, rest zero
	output logic [1:0]  m_axis_tuser   // [1:0] status
);
	import kthc_pkg::*;

	localparam int CNT_W = $clog2(ENTRIES + 1);

	// command register
	logic             busy_q;
	logic [OP_W-1:0]  op_q;
	logic [KEY_W-1:0] key_q;
	logic             exec_fire;
	cell_cmd_t        cmd;

	// cell row
	logic [ENTRIES:0]   taken;
	logic [ENTRIES-1:0] claim;
	logic [ENTRIES-1:0] valid_vec;
	logic [HITS_W-1:0]  cell_hits [ENTRIES];

	// gathered result
	logic [HITS_W-1:0]  hits_sel;
	logic [SLOT_W-1:0]  slot_sel;
	logic               any_claim;
	status_t            status_nx;
	logic [CNT_W-1:0]   occ_nx;
	logic [TOTAL_W-1:0] total_nx;

	// persistent counters and result register
	logic [CNT_W-1:0]    occupied_q;
	logic [TOTAL_W-1:0]  total_q;
	logic                m_valid_q;
	logic [M_DATA_W-1:0] m_data_q;
	logic [STATUS_W-1:0] m_user_q;

	assign exec_fire     = busy_q && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !busy_q || exec_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			busy_q <= 1'b1;
		end else if (exec_fire) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_q  <= s_axis_tuser;
			key_q <= s_axis_tdata;
		end
	end

	assign cmd.fire = exec_fire;
	assign cmd.op   = op_q;
	assign cmd.key  = key_q;

	assign taken[0] = 1'b0;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		kthc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.claim     (claim[i]),
			.valid     (valid_vec[i]),
			.hits      (cell_hits[i])
		);
	end

	assign any_claim = taken[ENTRIES];

	// at most one cell claims, so an OR gathers its values
	always_comb begin
		hits_sel = '0;
		slot_sel = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hits_sel = hits_sel | cell_hits[i];
			slot_sel = slot_sel | (claim[i] ? SLOT_W'(i) : '0);
		end
	end

	always_comb begin
		status_nx = ST_OK;
		occ_nx    = occupied_q;
		total_nx  = total_q;
		case (op_q)
			OP_INSERT: begin
				if (!any_claim) begin
					status_nx = ST_FULL;
				end else begin
					occ_nx = occupied_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (!any_claim) begin
					status_nx = ST_MISSING;
				end else begin
					occ_nx = occupied_q - 1'b1;
				end
			end
			OP_LOOKUP: begin
				if (!any_claim) begin
					status_nx = ST_MISSING;
				end
			end
			OP_HIT: begin
				if (!any_claim) begin
					status_nx = ST_MISSING;
				end else if (total_q != {TOTAL_W{1'b1}}) begin
					total_nx = total_q + 1'b1;
				end
			end
			default: begin
				status_nx = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q <= '0;
			total_q    <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (exec_fire) begin
				occupied_q <= occ_nx;
				total_q    <= total_nx;
				m_valid_q  <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			m_user_q <= status_nx;
			m_data_q <= {{(M_DATA_W - SLOT_W - HITS_W - OCC_W - TOTAL_W){1'b0}},
				total_nx, OCC_W'(occ_nx), hits_sel, slot_sel};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// occupancy tracks the valid flags held in the cells
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == 32'(occupied_q))
		else $error("occupancy count differs from valid flags");

	// the priority link lets at most one cell act
	a_single_claim: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(claim))
		else $error("more than one cell claimed the command");

	// a successful insert grows the occupancy by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && (op_q == OP_INSERT) && any_claim
		|=> occupied_q == $past(occupied_q) + 1'b1)
		else $error("insert did not raise occupancy");

	// the total never goes down
	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> total_q >= $past(total_q))
		else $error("total hit count decreased");

	// no result is produced without a command in the command register
	a_result_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(busy_q))
		else $error("result beat without a command");

endmodule

// File: rtl/core/kthc_cell.sv
// One table slot: valid flag, key, saturating hit counter and priority link.
`timescale 1ns / 1ps

module kthc_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kthc_pkg::cell_cmd_t        cmd,
	input  logic                       taken_in,   // a lower slot already claimed the op
	output logic                       taken_out,
	output logic                       claim,
	output logic                       valid,
	output logic [kthc_pkg::HITS_W-1:0] hits
);
	import kthc_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [HITS_W-1:0] cnt_q;
	logic              want;
	logic              hit_match;
	logic [HITS_W-1:0] cnt_inc;
	logic [HITS_W-1:0] cnt_next;

	assign hit_match = valid_q && (key_q == cmd.key);
	assign cnt_inc   = (cnt_q == {HITS_W{1'b1}}) ? cnt_q : cnt_q + 1'b1;

	always_comb begin
		case (cmd.op)
			OP_INSERT: want = !valid_q;
			OP_DELETE,
			OP_LOOKUP,
			OP_HIT:    want = hit_match;
			default:   want = 1'b0;
		endcase
	end

	always_comb begin
		case (cmd.op)
			OP_INSERT: cnt_next = '0;
			OP_HIT:    cnt_next = cnt_inc;
			default:   cnt_next = cnt_q;
		endcase
	end

	assign claim     = want && !taken_in;
	assign taken_out = taken_in || want;
	assign valid     = valid_q;
	assign hits      = claim ? cnt_next : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.fire && claim) begin
			if (cmd.op == OP_INSERT) begin
				valid_q <= 1'b1;
			end else if (cmd.op == OP_DELETE) begin
				valid_q <= 1'b0;
			end
		end
	end

	// payload, no reset: only read once the slot is valid
	always_ff @(posedge clk) begin
		if (cmd.fire && claim) begin
			if (cmd.op == OP_INSERT) begin
				key_q <= cmd.key;
			end
			cnt_q <= cnt_next;
		end
	end

endmodule
